/* hdl/tps_pkg.sv */
// Shared types, constants and tables for the turtle pose stepper.
`timescale 1ns / 1ps

package tps_pkg;

  localparam int unsigned CordicStepsDef = 16;
  localparam int unsigned AngleBitsDef   = 16;

  localparam int unsigned DistW = 20;
  localparam int unsigned TurnW = 16;
  localparam int unsigned HeadW = 16;
  localparam int unsigned PosW  = 24;

  // CORDIC datapath width, Q2.30 with headroom
  localparam int unsigned CordW = 33;
  localparam int unsigned ProdW = DistW + CordW;

  localparam logic signed [CordW-1:0] CordicGain = CordW'(652032874);

  localparam logic signed [PosW-1:0] PosMax = PosW'(8388607);
  localparam logic signed [PosW-1:0] PosMin = PosW'(-8388608);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROT,
    ST_MULX,
    ST_MULY,
    ST_WRITE
  } state_e;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41721;
      5'd15:   v = 32'd20860;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2607;
      5'd19:   v = 32'd1303;
      5'd20:   v = 32'd651;
      5'd21:   v = 32'd325;
      5'd22:   v = 32'd162;
      default: v = 32'd81;
    endcase
    return v;
  endfunction

endpackage

/* hdl/turtle_pose_stepper.sv */
// Turtle pose stepper: pen pose, iterative CORDIC and segment output.
`timescale 1ns / 1ps

// Keeps a pen position (Q15.8, saturating) and a 16-bit wrapping heading.
// A turn request only adds to the heading and emits nothing; turns can be taken
// back to back while idle. A move request runs a rotation-mode CORDIC on one
// shared add/shift unit, one step per cycle, then uses one shared multiplier
// twice to scale cosine and sine by the distance, and emits one segment.
// A move holds the input stalled from ST_ROT through ST_MULX and ST_MULY to
// ST_WRITE, which also waits while the previous segment is still held in
// the output register. The segment stays in that register until taken, so
// the next request is accepted while it waits.
module turtle_pose_stepper #(
  parameter int unsigned CORDIC_STEPS = tps_pkg::CordicStepsDef,
  parameter int unsigned ANGLE_BITS   = tps_pkg::AngleBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,

  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              operation_i,
  input  logic signed [tps_pkg::DistW-1:0]  distance_i,
  input  logic signed [tps_pkg::TurnW-1:0]  turn_angle_i,

  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [tps_pkg::PosW-1:0]   start_x_o,
  output logic signed [tps_pkg::PosW-1:0]   start_y_o,
  output logic signed [tps_pkg::PosW-1:0]   end_x_o,
  output logic signed [tps_pkg::PosW-1:0]   end_y_o
);
  import tps_pkg::*;

  localparam int unsigned ZW = ANGLE_BITS + 1;
  localparam int unsigned SW = $clog2(CORDIC_STEPS);
  localparam int unsigned DxW = ProdW - 30;

  state_e state_q, state_d;

  logic                     out_valid_q;
  logic                     out_valid_d;
  logic signed [PosW-1:0]   pos_x_q, pos_y_q;
  logic [HeadW-1:0]         heading_q;
  logic signed [DistW-1:0]  dist_q;
  logic signed [CordW-1:0]  x_q, y_q;
  logic signed [ZW-1:0]     z_q;
  logic [1:0]               quad_q;
  logic [SW-1:0]            step_q;
  logic signed [ProdW-1:0]  prod_q;
  logic signed [PosW-1:0]   end_x_q;
  logic signed [PosW-1:0]   start_x_q, start_y_q, out_end_x_q, out_end_y_q;

  logic                     accept;
  logic                     take_move;
  logic                     take_turn;
  logic                     last_step;
  logic                     load_out;

  logic [31:0]              r_ang;
  logic signed [ZW-1:0]     z_init;
  logic [32:0]              ang_sum;
  logic signed [ZW-1:0]     ang_step;
  logic signed [CordW-1:0]  xs, ys;
  logic signed [CordW-1:0]  x_d, y_d;
  logic signed [ZW-1:0]     z_d;
  logic signed [CordW-1:0]  cos_v, sin_v, mul_b;
  logic signed [ProdW-1:0]  prod_d;
  logic signed [PosW-1:0]   sat_res;
  logic signed [PosW-1:0]   sat_base;

  function automatic logic signed [PosW-1:0] sat_move(
    input logic signed [PosW-1:0]  base,
    input logic signed [ProdW-1:0] prod
  );
    logic signed [ProdW-1:0] rnd;
    logic signed [DxW-1:0]   dx;
    logic signed [PosW+1:0]  sum;
    rnd = prod + ProdW'(64'd1 << 29);
    dx  = rnd[ProdW-1:30];
    sum = (PosW+2)'(base) + (PosW+2)'(dx);
    if (sum > (PosW+2)'(PosMax)) begin
      return PosMax;
    end else if (sum < (PosW+2)'(PosMin)) begin
      return PosMin;
    end
    return sum[PosW-1:0];
  endfunction

  assign accept    = in_valid_i && !in_stall_o;
  assign take_move = accept && !operation_i;
  assign take_turn = accept && operation_i;
  assign last_step = (step_q == SW'(CORDIC_STEPS - 1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (take_move) state_d = ST_ROT;
      ST_ROT:   if (last_step) state_d = ST_MULX;
      ST_MULX:  state_d = ST_MULY;
      ST_MULY:  state_d = ST_WRITE;
      ST_WRITE: if (load_out) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall_o = 1'b1;
    load_out   = 1'b0;
    unique case (state_q)
      ST_IDLE:  in_stall_o = 1'b0;
      ST_WRITE: load_out   = !(out_valid_q && out_stall_i);
      default:  ;
    endcase
  end

  // quadrant split of the heading
  assign r_ang  = {heading_q, 16'h0000} + 32'h2000_0000;
  assign z_init = $signed({3'b000, r_ang[29:32-ANGLE_BITS]})
                - ZW'(64'd1 << (ANGLE_BITS - 3));

  // shared rotation unit
  assign ang_sum  = {1'b0, atan_turn(5'(step_q))} + 33'(64'd1 << (31 - ANGLE_BITS));
  assign ang_step = ZW'(ang_sum >> (32 - ANGLE_BITS));
  assign xs       = x_q >>> step_q;
  assign ys       = y_q >>> step_q;

  always_comb begin
    if (!z_q[ZW-1]) begin
      x_d = x_q - ys;
      y_d = y_q + xs;
      z_d = z_q - ang_step;
    end else begin
      x_d = x_q + ys;
      y_d = y_q - xs;
      z_d = z_q + ang_step;
    end
  end

  always_comb begin
    case (quad_q)
      2'd0:    begin cos_v = x_q;  sin_v = y_q;  end
      2'd1:    begin cos_v = -y_q; sin_v = x_q;  end
      2'd2:    begin cos_v = -x_q; sin_v = -y_q; end
      default: begin cos_v = y_q;  sin_v = -x_q; end
    endcase
  end

  // shared multiplier
  assign mul_b    = (state_q == ST_MULX) ? cos_v : sin_v;
  assign prod_d   = ProdW'(dist_q) * ProdW'(mul_b);
  assign sat_base = (state_q == ST_MULY) ? pos_x_q : pos_y_q;
  assign sat_res  = sat_move(sat_base, prod_q);

  assign out_valid_d = load_out ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      heading_q   <= '0;
      step_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (take_turn) begin
        heading_q <= heading_q + HeadW'(turn_angle_i);
      end
      if (take_move) begin
        step_q <= '0;
      end else if (state_q == ST_ROT && !last_step) begin
        step_q <= step_q + SW'(1);
      end
      if (load_out) begin
        pos_x_q <= end_x_q;
        pos_y_q <= sat_res;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_move) begin
      dist_q <= distance_i;
      x_q    <= CordicGain;
      y_q    <= '0;
      z_q    <= z_init;
      quad_q <= r_ang[31:30];
    end else if (state_q == ST_ROT) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
    if (state_q == ST_MULX || state_q == ST_MULY) begin
      prod_q <= prod_d;
    end
    if (state_q == ST_MULY) begin
      end_x_q <= sat_res;
    end
    if (load_out) begin
      start_x_q   <= pos_x_q;
      start_y_q   <= pos_y_q;
      out_end_x_q <= end_x_q;
      out_end_y_q <= sat_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign start_x_o   = start_x_q;
  assign start_y_o   = start_y_q;
  assign end_x_o     = out_end_x_q;
  assign end_y_o     = out_end_y_q;

  a_out_from_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_WRITE))
    else $error("segment raised without a finished move");

  a_pos_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_WRITE) |=> $stable(pos_x_q) && $stable(pos_y_q))
    else $error("position changed outside segment write");

  a_heading_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !take_turn |=> $stable(heading_q))
    else $error("heading changed without a turn request");

  a_end_matches_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> (end_x_o == pos_x_q) && (end_y_o == pos_y_q))
    else $error("segment end differs from new position");

endmodule

/* bench/tps_segment_checker.sv */
// Request codes and the segment checker that predicts the pen pose and compares segments.
`timescale 1ns / 1ps

package tps_bench_pkg;

  typedef enum logic {
    OP_MOVE = 1'b0,
    OP_TURN = 1'b1
  } op_e;

endpackage

module tps_segment_checker #(
  parameter int unsigned CORDIC_STEPS = tps_pkg::CordicStepsDef,
  parameter int unsigned ANGLE_BITS   = tps_pkg::AngleBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic                              operation_i,
  input  logic signed [tps_pkg::DistW-1:0]  distance_i,
  input  logic signed [tps_pkg::TurnW-1:0]  turn_angle_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic signed [tps_pkg::PosW-1:0]   start_x_i,
  input  logic signed [tps_pkg::PosW-1:0]   start_y_i,
  input  logic signed [tps_pkg::PosW-1:0]   end_x_i,
  input  logic signed [tps_pkg::PosW-1:0]   end_y_i,
  output int                                errors_o,
  output int                                pending_o,
  output int                                segments_o,
  output int                                turns_o,
  output int                                clamps_o
);

  import tps_pkg::PosW;
  import tps_pkg::DistW;
  import tps_bench_pkg::*;

  localparam longint PenMax = 64'sd8388607;
  localparam longint PenMin = -64'sd8388608;
  localparam longint UnitGain = 64'sd652032874;

  // arctangent of 2^-i in 2^-32 turn, entry 0 in the low word
  localparam logic [24*32-1:0] AtanTable = {
    32'd81,       32'd162,      32'd325,      32'd651,
    32'd1303,     32'd2607,     32'd5215,     32'd10430,
    32'd20860,    32'd41721,    32'd83443,    32'd166886,
    32'd333772,   32'd667544,   32'd1335087,  32'd2670163,
    32'd5340245,  32'd10679838, 32'd21354465, 32'd42667331,
    32'd85004756, 32'd167458907, 32'd316933406, 32'd536870912
  };

  typedef struct {
    logic signed [PosW-1:0] start_x;
    logic signed [PosW-1:0] start_y;
    logic signed [PosW-1:0] end_x;
    logic signed [PosW-1:0] end_y;
  } segment_t;

  segment_t    segment_q[$];
  longint      pen_x;
  longint      pen_y;
  logic [15:0] pen_heading;
  int          errors;
  int          segments;
  int          turns;
  int          clamps;

  function automatic longint atan_step(input int unsigned i);
    int unsigned idx;
    longint      raw;
    idx = (i > 23) ? 23 : i;
    raw = longint'({32'd0, AtanTable[idx*32 +: 32]});
    return (raw + (longint'(1) << (31 - ANGLE_BITS))) >>> (32 - ANGLE_BITS);
  endfunction

  task automatic heading_trig(input logic [15:0] hd, output longint cos_v,
                              output longint sin_v);
    logic [31:0] phase;
    logic [1:0]  quad;
    longint      cx;
    longint      cy;
    longint      z;
    longint      sx;
    longint      sy;
    phase = {hd, 16'h0000} + 32'h2000_0000;
    quad  = phase[31:30];
    z  = longint'({34'd0, phase[29:0]} >> (32 - ANGLE_BITS))
         - (longint'(1) << (ANGLE_BITS - 3));
    cx = UnitGain;
    cy = 0;
    for (int unsigned i = 0; i < CORDIC_STEPS; i++) begin
      sx = cx >>> i;
      sy = cy >>> i;
      if (z >= 0) begin
        cx = cx - sy;
        cy = cy + sx;
        z  = z - atan_step(i);
      end else begin
        cx = cx + sy;
        cy = cy - sx;
        z  = z + atan_step(i);
      end
    end
    case (quad)
      2'd0: begin
        cos_v = cx;
        sin_v = cy;
      end
      2'd1: begin
        cos_v = -cy;
        sin_v = cx;
      end
      2'd2: begin
        cos_v = -cx;
        sin_v = -cy;
      end
      default: begin
        cos_v = cy;
        sin_v = -cx;
      end
    endcase
  endtask

  function automatic longint clamp_pen(input longint v);
    if (v > PenMax) return PenMax;
    if (v < PenMin) return PenMin;
    return v;
  endfunction

  task automatic advance_pen(input logic signed [DistW-1:0] move_dist, output segment_t seg);
    longint d;
    longint c;
    longint s;
    longint raw_x;
    longint raw_y;
    longint nx;
    longint ny;
    d = longint'(move_dist);
    heading_trig(pen_heading, c, s);
    raw_x = pen_x + ((d * c + (longint'(1) << 29)) >>> 30);
    raw_y = pen_y + ((d * s + (longint'(1) << 29)) >>> 30);
    nx = clamp_pen(raw_x);
    ny = clamp_pen(raw_y);
    if (nx != raw_x || ny != raw_y) clamps++;
    seg.start_x = pen_x[PosW-1:0];
    seg.start_y = pen_y[PosW-1:0];
    seg.end_x   = nx[PosW-1:0];
    seg.end_y   = ny[PosW-1:0];
    pen_x = nx;
    pen_y = ny;
  endtask

  task automatic check_coord(input string label, input logic signed [PosW-1:0] want,
                             input logic signed [PosW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", label, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    segment_t seg;
    if (!rst_ni) begin
      segment_q.delete();
      pen_x = 0;
      pen_y = 0;
      pen_heading = '0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (segment_q.size() == 0) begin
          $error("segment emitted with no move request waiting");
          errors++;
        end else begin
          seg = segment_q.pop_front();
          check_coord("start_x", seg.start_x, start_x_i);
          check_coord("start_y", seg.start_y, start_y_i);
          check_coord("end_x", seg.end_x, end_x_i);
          check_coord("end_y", seg.end_y, end_y_i);
          segments++;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (operation_i == OP_TURN) begin
          pen_heading = pen_heading + turn_angle_i;
          turns++;
        end else begin
          advance_pen(distance_i, seg);
          segment_q.push_back(seg);
        end
      end
    end
    errors_o   <= errors;
    pending_o  <= segment_q.size();
    segments_o <= segments;
    turns_o    <= turns;
    clamps_o   <= clamps;
  end

endmodule

/* bench/turtle_pose_stepper_test.sv */
// Top-level test of the turtle pose stepper: request stimulus, random stalls and verdict.
`timescale 1ns / 1ps

module turtle_pose_stepper_test;

  import tps_pkg::*;
  import tps_bench_pkg::*;

  localparam int ItemTarget  = 1000;
  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 40;

  logic                    clk;
  logic                    rst_n      = 1'b0;
  logic                    in_valid   = 1'b0;
  logic                    in_stall;
  logic                    operation  = OP_TURN;
  logic signed [DistW-1:0] distance   = '0;
  logic signed [TurnW-1:0] turn_angle = '0;
  logic                    out_valid;
  logic                    out_stall  = 1'b0;
  logic signed [PosW-1:0]  start_x;
  logic signed [PosW-1:0]  start_y;
  logic signed [PosW-1:0]  end_x;
  logic signed [PosW-1:0]  end_y;

  int          errors;
  int          pending;
  int          segments;
  int          turns;
  int          clamps;
  int          sent       = 0;
  int          cycle_count = 0;
  int          recv_hold  = 0;
  logic        rush       = 1'b0;
  logic [15:0] aim        = '0;

  turtle_pose_stepper dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .operation_i  (operation),
    .distance_i   (distance),
    .turn_angle_i (turn_angle),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .start_x_o    (start_x),
    .start_y_o    (start_y),
    .end_x_o      (end_x),
    .end_y_o      (end_y)
  );

  tps_segment_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .operation_i  (operation),
    .distance_i   (distance),
    .turn_angle_i (turn_angle),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .start_x_i    (start_x),
    .start_y_i    (start_y),
    .end_x_i      (end_x),
    .end_y_i      (end_y),
    .errors_o     (errors),
    .pending_o    (pending),
    .segments_o   (segments),
    .turns_o      (turns),
    .clamps_o     (clamps)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL turtle_pose_stepper");
    $finish;
  end

  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      recv_hold = rush ? 0 : $urandom_range(0, 13);
    end else if (out_valid && recv_hold != 0) begin
      recv_hold--;
    end
    out_stall <= (recv_hold != 0);
  end

  task automatic send_request(input op_e op, input logic signed [DistW-1:0] move_dist,
                              input logic signed [TurnW-1:0] ang);
    int gap;
    gap = rush ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_valid   <= 1'b0;
      operation  <= 1'($urandom);
      distance   <= DistW'($urandom);
      turn_angle <= TurnW'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    operation  <= op;
    distance   <= move_dist;
    turn_angle <= ang;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (op == OP_TURN) aim = aim + ang;
    sent++;
  endtask

  task automatic drain_segments();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int          n;
    int          len;
    logic [15:0] turn_step;
    logic [15:0] target;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send_request(OP_MOVE, 0, 0);
    send_request(OP_MOVE, 524287, -1);
    send_request(OP_MOVE, -524288, -32768);
    send_request(OP_TURN, -1, 16384);
    send_request(OP_MOVE, 524287, 32767);
    send_request(OP_TURN, 0, 32767);
    send_request(OP_MOVE, -524288, 0);
    send_request(OP_TURN, 524287, -32768);
    send_request(OP_MOVE, 1, 0);
    send_request(OP_TURN, 0, 8192);
    send_request(OP_MOVE, 524287, 0);
    send_request(OP_TURN, 0, -16384);
    send_request(OP_MOVE, -1, 0);
    send_request(OP_TURN, 0, 32767);
    send_request(OP_TURN, 0, 32767);
    send_request(OP_TURN, 0, 2);
    send_request(OP_MOVE, 300000, 0);
    send_request(OP_TURN, 0, -8193);
    send_request(OP_MOVE, -300000, 0);
    drain_segments();

    while (sent < ItemTarget) begin
      if ($urandom_range(0, 7) == 0) rush <= !rush;
      case ($urandom_range(0, 11))
        0, 1, 2: begin
          n = $urandom_range(3, 12);
          turn_step = 16'(65536 / n);
          if ($urandom_range(0, 1) == 1) turn_step = -turn_step;
          len = $urandom_range(0, 120000);
          repeat (n) begin
            send_request(OP_MOVE, DistW'(len), TurnW'($urandom));
            send_request(OP_TURN, DistW'($urandom), turn_step);
          end
        end
        3, 4: begin
          send_request(OP_TURN, 0, TurnW'($urandom));
          n = $urandom_range(12, 30);
          len = ($urandom_range(0, 3) == 0) ? 524287 : $urandom_range(480000, 524287);
          if ($urandom_range(0, 1) == 1) len = -len - 1;
          repeat (n) send_request(OP_MOVE, DistW'(len), 0);
        end
        5, 6: begin
          target = 16'($urandom_range(0, 7) * 8192 + $urandom_range(0, 2) - 1);
          send_request(OP_TURN, 0, target - aim);
          send_request(OP_MOVE, DistW'($urandom), 0);
        end
        7: begin
          len = $urandom_range(0, 524287);
          send_request(OP_MOVE, DistW'(len), 0);
          send_request(OP_MOVE, DistW'(-len), 0);
        end
        8, 9, 10: begin
          repeat ($urandom_range(2, 6)) begin
            send_request(op_e'($urandom_range(0, 1)), DistW'($urandom), TurnW'($urandom));
          end
        end
        default: begin
          drain_segments();
        end
      endcase
    end

    drain_segments();
    repeat (DrainCycles) @(posedge clk);

    $display("Run covered %0d requests: %0d segments checked, %0d turns, %0d clamped moves.",
             sent, segments, turns, clamps);
    if (errors == 0) begin
      $display("PASS turtle_pose_stepper");
    end else begin
      $display("FAIL turtle_pose_stepper");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/tps_pkg.sv
hdl/turtle_pose_stepper.sv
bench/tps_segment_checker.sv
bench/turtle_pose_stepper_test.sv
